FILE: design/kpl_pkg.sv
// Package for the keypad code lock: phase and event codes, register
// indexes, the key map and the motor command table.
// No dependencies; used by keypad_password_lock_core and kpl_checker.
`default_nettype none

package kpl_pkg;

   // lock phase as reported in lock_phase
   typedef enum logic [1:0] {
      PH_ENTRY   = 2'd0,
      PH_GRANTED = 2'd1,
      PH_COMMAND = 2'd2
   } phase_type;

   // event reported with each result word
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_MATCH   = 3'd1,
      EV_DENIED  = 3'd2,
      EV_LOCKOUT = 3'd3,
      EV_COMMAND = 3'd4
   } event_type;

   // configuration register indexes
   typedef enum logic {
      REG_CODE_WORD     = 1'b0,
      REG_LOCKOUT_LIMIT = 1'b1
   } reg_index_type;

   localparam int CodeWordWidth = 40;
   localparam int LimitWidth    = 8;
   localparam int KeyWidth      = 7;
   localparam int CountWidth    = 8;
   localparam logic [CodeWordWidth-1:0] CodeWordReset = 40'h31_32_33_34_35;
   localparam logic [LimitWidth-1:0]    LimitReset    = 8'd3;
   localparam logic [CountWidth-1:0]    CountMax      = 8'hFF;

   // ASCII of the key at a column and row of the 4x4 matrix
   function automatic logic [KeyWidth-1:0] key_of(input logic [1:0] col,
                                                  input logic [1:0] row);
      logic [KeyWidth-1:0] k;
      case ({col, row})
         4'h0: k = 7'h37;  // 7
         4'h1: k = 7'h34;  // 4
         4'h2: k = 7'h31;  // 1
         4'h3: k = 7'h40;  // @
         4'h4: k = 7'h38;  // 8
         4'h5: k = 7'h35;  // 5
         4'h6: k = 7'h32;  // 2
         4'h7: k = 7'h30;  // 0
         4'h8: k = 7'h39;  // 9
         4'h9: k = 7'h36;  // 6
         4'hA: k = 7'h33;  // 3
         4'hB: k = 7'h3D;  // =
         4'hC: k = 7'h2F;  // /
         4'hD: k = 7'h78;  // x
         4'hE: k = 7'h2D;  // -
         default: k = 7'h2B;  // +
      endcase
      return k;
   endfunction

   // motor drive nibble selected by a command key
   function automatic logic [3:0] motor_of(input logic [KeyWidth-1:0] k);
      logic [3:0] m;
      case (k)
         7'h32:   m = 4'b1010;  // 2: forward
         7'h34:   m = 4'b0010;  // 4: right
         7'h36:   m = 4'b1000;  // 6: left
         7'h38:   m = 4'b0101;  // 8: back
         default: m = 4'b0000;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: design/keypad_password_lock_core.sv
// Top level of the keypad code lock: column scanner, key release detect,
// code entry and compare, failure count and command decode.
// Depends on kpl_pkg.
`default_nettype none

// Channel  Dir  Ports                    Content
// req      in   req_tvalid/tready/tdata  tdata[3:0] row_lines, [7:4] zero
// rsp      out  rsp_tvalid/tready/tdata  tdata: see port; tuser key_valid
// csr      in   csr_we/csr_addr/csr_wdata  0 code_word, 1 lockout_limit
//
// One scan tick per cycle unless the result register is stalled; a word
// passes the input register and then the result register. The lock state
// advances as a word leaves the input register, and the stage only holds
// while the result register is full and stalled.
// Reset clears the scanner, phase, entry count and failure count; the code
// and the limit return to "12345" and 3.
module keypad_password_lock_core #(
   parameter int CODE_LENGTH = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [3:0] row_lines, [7:4] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] column_drive, [10:4] key_char, [12:11] lock_phase,
   // [15:13] event_code, [19:16] motor_pattern, [27:20] failure_count
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tuser,   // [0] key_valid
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [39:0] csr_wdata
);

   localparam int CntW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [CntW-1:0] LastIdx = CntW'(CODE_LENGTH - 1);

   // configuration
   logic [kpl_pkg::CodeWordWidth-1:0] code_ff;
   logic [kpl_pkg::LimitWidth-1:0]    limit_ff;

   // input stage
   logic       in_valid_ff;
   logic [3:0] in_rows_ff;
   logic       advance;

   // lock state
   logic [1:0]                   scan_col_ff, scan_col_in;
   logic                         release_ff, release_in;
   logic [1:0]                   held_row_ff, held_row_in;
   logic [kpl_pkg::KeyWidth-1:0] keys_ff [CODE_LENGTH];
   logic [CntW-1:0]              count_ff, count_in;
   kpl_pkg::phase_type           phase_ff, phase_in;
   logic [kpl_pkg::CountWidth-1:0] wrong_ff, wrong_in;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_user_ff;

   // per-tick decode
   logic                         any_low;
   logic [1:0]                   low_row;
   logic                         key_done;
   logic [kpl_pkg::KeyWidth-1:0] key;
   logic                         code_full;
   logic                         matched;
   logic [63:0]                  code_ext;
   kpl_pkg::event_type           event_code;
   logic [3:0]                   motor;
   logic [3:0]                   col_drive;

   // take config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= kpl_pkg::CodeWordReset;
         limit_ff <= kpl_pkg::LimitReset;
      end else if (csr_we) begin
         case (kpl_pkg::reg_index_type'(csr_addr))
            kpl_pkg::REG_CODE_WORD:     code_ff  <= csr_wdata;
            kpl_pkg::REG_LOCKOUT_LIMIT: limit_ff <= csr_wdata[kpl_pkg::LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   // input stage moves on when the result register is free or drains
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_rows_ff <= req_tdata[3:0];
      end
   end

   // find the lowest low row
   assign any_low = ~&in_rows_ff;
   always_comb begin
      if (!in_rows_ff[0])      low_row = 2'd0;
      else if (!in_rows_ff[1]) low_row = 2'd1;
      else if (!in_rows_ff[2]) low_row = 2'd2;
      else                     low_row = 2'd3;
   end

   // key completes when the held row reads high again
   assign key_done = release_ff && in_rows_ff[held_row_ff];
   assign key      = key_done ? kpl_pkg::key_of(scan_col_ff, held_row_ff) : '0;

   assign code_full = (phase_ff != kpl_pkg::PH_GRANTED) &&
                      (phase_ff != kpl_pkg::PH_COMMAND) && (count_ff == LastIdx);
   assign code_ext  = {{(64 - kpl_pkg::CodeWordWidth){1'b0}}, code_ff};

   // compare stored keys plus the current one against the code bytes
   always_comb begin
      logic [7:0] got;
      matched = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         got = (i == CODE_LENGTH - 1) ? {1'b0, key} : {1'b0, keys_ff[i]};
         if (got != code_ext[8*(CODE_LENGTH-1-i) +: 8]) begin
            matched = 1'b0;
         end
      end
   end

   // next scanner, entry and phase state
   always_comb begin
      scan_col_in = scan_col_ff;
      release_in  = release_ff;
      held_row_in = held_row_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      wrong_in    = wrong_ff;
      if (!release_ff) begin
         if (any_low) begin
            held_row_in = low_row;
            release_in  = 1'b1;
         end else begin
            scan_col_in = scan_col_ff + 2'd1;
         end
      end else if (key_done) begin
         release_in  = 1'b0;
         scan_col_in = 2'd0;
      end
      if (key_done) begin
         unique case (phase_ff)
            kpl_pkg::PH_GRANTED: phase_in = kpl_pkg::PH_COMMAND;
            kpl_pkg::PH_COMMAND: phase_in = kpl_pkg::PH_ENTRY;
            default: begin
               phase_in = kpl_pkg::PH_ENTRY;
               if (code_full) begin
                  count_in = '0;
                  if (matched) begin
                     wrong_in = '0;
                     phase_in = kpl_pkg::PH_GRANTED;
                  end else if (wrong_ff != kpl_pkg::CountMax) begin
                     wrong_in = wrong_ff + 8'd1;
                  end
               end else begin
                  count_in = count_ff + CntW'(1);
               end
            end
         endcase
      end
   end

   // event, motor and column outputs of this tick
   always_comb begin
      event_code = kpl_pkg::EV_NONE;
      motor      = 4'd0;
      if (key_done) begin
         unique case (phase_ff)
            kpl_pkg::PH_GRANTED: event_code = kpl_pkg::EV_NONE;
            kpl_pkg::PH_COMMAND: begin
               event_code = kpl_pkg::EV_COMMAND;
               motor      = kpl_pkg::motor_of(key);
            end
            default: begin
               if (code_full) begin
                  if (matched) begin
                     event_code = kpl_pkg::EV_MATCH;
                  end else if (wrong_in != wrong_ff && wrong_in == limit_ff) begin
                     event_code = kpl_pkg::EV_LOCKOUT;
                  end else begin
                     event_code = kpl_pkg::EV_DENIED;
                  end
               end
            end
         endcase
      end
      col_drive = ~(4'b0001 << scan_col_in);
   end

   // commit lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= 2'd0;
         release_ff  <= 1'b0;
         held_row_ff <= 2'd0;
         count_ff    <= '0;
         phase_ff    <= kpl_pkg::PH_ENTRY;
         wrong_ff    <= '0;
      end else if (advance) begin
         scan_col_ff <= scan_col_in;
         release_ff  <= release_in;
         held_row_ff <= held_row_in;
         count_ff    <= count_in;
         phase_ff    <= phase_in;
         wrong_ff    <= wrong_in;
      end
   end

   // store the entered key
   always_ff @(posedge clock) begin
      if (advance && key_done && phase_ff != kpl_pkg::PH_GRANTED &&
          phase_ff != kpl_pkg::PH_COMMAND) begin
         keys_ff[count_ff] <= key;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {4'd0, wrong_in, motor, event_code, phase_in, key, col_drive};
         rsp_user_ff <= key_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: design/kpl_checker.sv
// Port-level checks for the keypad code lock, bound to its top level.
// Depends on kpl_pkg and keypad_password_lock_core.
`default_nettype none

module kpl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // exactly one column driven low
   a_one_column: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(~rsp_tdata[3:0]))
      else $error("column drive not one-cold");

   // no key means no character, no event and no motor drive
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[10:4] == 7'd0 && rsp_tdata[15:13] == kpl_pkg::EV_NONE &&
         rsp_tdata[19:16] == 4'd0)
      else $error("event without a key");

   // a match grants access and clears the failure count
   a_match_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:13] == kpl_pkg::EV_MATCH |->
         rsp_tdata[12:11] == kpl_pkg::PH_GRANTED && rsp_tdata[27:20] == 8'd0)
      else $error("match without grant");

endmodule

bind keypad_password_lock_core kpl_checker u_kpl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
